// File: src/amig_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturation helpers for the impedance gain core.
// No dependencies.
package amig_pkg;

  localparam int DIV_STAGES = 32;
  localparam logic [31:0] QONE = 32'd65536;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;
  localparam logic signed [31:0] K_MAX = 32'sd32768000;
  localparam logic signed [31:0] D_MAX = 32'sd327680;
  localparam logic signed [31:0] FF_LIM = 32'sd983040;

  typedef enum logic [1:0] {
    REG_GAIN_A = 2'd0,
    REG_GAIN_B = 2'd1,
    REG_BETA   = 2'd2,
    REG_NONE   = 2'd3
  } cfg_reg_t;

  // errors that travel with an item down the pipeline
  typedef struct packed {
    logic signed [31:0] ep;
    logic signed [31:0] ev;
    logic               sat;
  } ctx_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } satv_t;

  function automatic satv_t sat32(input logic signed [65:0] x);
    satv_t r;
    if (x > 66'sd2147483647) begin
      r = '{sat: 1'b1, val: S32_MAX};
    end else if (x < -66'sd2147483648) begin
      r = '{sat: 1'b1, val: S32_MIN};
    end else begin
      r = '{sat: 1'b0, val: x[31:0]};
    end
    return r;
  endfunction

  // Q16.16 product scaling: floor shift, then saturate
  function automatic satv_t qsat(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> 16;
    return sat32(66'(s));
  endfunction

endpackage

// File: src/amig_in_if.sv
`timescale 1ns / 1ps
// Input item channel: valid/ready with desired and measured state.
// No dependencies.
interface amig_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] desired_position;
  logic signed [31:0] desired_velocity;
  logic signed [31:0] measured_position;
  logic signed [31:0] measured_velocity;

  modport source(output valid, desired_position, desired_velocity, measured_position,
                 measured_velocity, input ready);
  modport sink(input valid, desired_position, desired_velocity, measured_position,
               measured_velocity, output ready);
endinterface

// File: src/amig_out_if.sv
`timescale 1ns / 1ps
// Result item channel: valid/ready with gains, feed-forward and torque.
// No dependencies.
interface amig_out_if;
  logic               valid;
  logic               ready;
  logic        [24:0] stiffness;
  logic        [18:0] damping;
  logic signed [20:0] feedforward_force;
  logic signed [31:0] torque;
  logic               torque_saturated;

  modport source(output valid, stiffness, damping, feedforward_force, torque,
                 torque_saturated, input ready);
  modport sink(input valid, stiffness, damping, feedforward_force, torque,
               torque_saturated, output ready);
endinterface

// File: src/amig_front.sv
`timescale 1ns / 1ps
// Front pipeline: errors, track error and numerator e*(1+b*e*e), eight stages.
// Depends on amig_pkg.
module amig_front import amig_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] pd,
  input  logic signed [31:0] vd,
  input  logic signed [31:0] pf,
  input  logic signed [31:0] vf,
  input  logic        [31:0] gain_b,
  input  logic        [31:0] beta,
  output logic               out_valid,
  output logic signed [63:0] num,
  output ctx_t               ctx
);

  logic [7:0] v_r;
  ctx_t c1_r, c2_r, c3_r, c4_r, c5_r, c6_r, c7_r, c8_r;
  logic signed [64:0] pbv_r;
  logic signed [31:0] e3_r, e4_r, e5_r, e6_r, e7_r;
  logic signed [63:0] ee_r;
  logic signed [31:0] e2_r;
  logic signed [64:0] be_r;
  logic signed [31:0] den_r;
  logic signed [63:0] num_r;

  satv_t s_ep, s_ev, s_bv, s_e, s_e2, s_be, s_den;

  always_comb begin
    s_ep  = sat32(66'(pf) - 66'(pd));
    s_ev  = sat32(66'(vf) - 66'(vd));
    s_bv  = qsat(pbv_r[63:0]);
    s_e   = sat32(66'(c2_r.ep) + 66'(s_bv.val));
    s_e2  = qsat(ee_r);
    s_be  = qsat(be_r[63:0]);
    s_den = sat32(66'($signed({1'b0, QONE})) + 66'(s_be.val));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r  <= '{ep: s_ep.val, ev: s_ev.val, sat: s_ep.sat | s_ev.sat};
      pbv_r <= $signed({1'b0, beta}) * c1_r.ev;
      c2_r  <= c1_r;
      e3_r  <= s_e.val;
      c3_r  <= '{ep: c2_r.ep, ev: c2_r.ev, sat: c2_r.sat | s_bv.sat | s_e.sat};
      ee_r  <= e3_r * e3_r;
      e4_r  <= e3_r;
      c4_r  <= c3_r;
      e2_r  <= s_e2.val;
      e5_r  <= e4_r;
      c5_r  <= '{ep: c4_r.ep, ev: c4_r.ev, sat: c4_r.sat | s_e2.sat};
      be_r  <= $signed({1'b0, gain_b}) * e2_r;
      e6_r  <= e5_r;
      c6_r  <= c5_r;
      den_r <= s_den.val;
      e7_r  <= e6_r;
      c7_r  <= '{ep: c6_r.ep, ev: c6_r.ev, sat: c6_r.sat | s_be.sat | s_den.sat};
      num_r <= e7_r * den_r;
      c8_r  <= c7_r;
    end
  end

  assign out_valid = v_r[7];
  assign num       = num_r;
  assign ctx       = c8_r;

endmodule

// File: src/amig_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, forms F = num / a.
// Depends on amig_pkg.
module amig_div import amig_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [63:0] num,
  input  ctx_t               in_ctx,
  input  logic        [31:0] gain_a,
  output logic               out_valid,
  output logic signed [31:0] f,
  output ctx_t               out_ctx
);

  // index 0 is the prep stage, index DIV_STAGES the last quotient bit
  logic [DIV_STAGES:0]        v_r;
  logic [31:0]                rem_r [DIV_STAGES+1];
  logic [31:0]                low_r [DIV_STAGES+1];
  logic [31:0]                q_r   [DIV_STAGES+1];
  logic [DIV_STAGES:0]        neg_r, ovf_r, az_r, nz_r;
  ctx_t                       c_r   [DIV_STAGES+1];

  logic               fv_r;
  logic signed [31:0] f_r;
  ctx_t               fc_r;

  logic [62:0] mag;
  logic        neg;

  always_comb begin
    neg = num[63];
    mag = neg ? 63'(-num) : num[62:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      fv_r <= 1'b0;
    end else if (en) begin
      v_r  <= {v_r[DIV_STAGES-1:0], in_valid};
      fv_r <= v_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {1'b0, mag[62:32]};
      low_r[0] <= mag[31:0];
      q_r[0]   <= '0;
      neg_r[0] <= neg;
      ovf_r[0] <= {1'b0, mag[62:32]} >= gain_a;
      az_r[0]  <= gain_a == '0;
      nz_r[0]  <= mag != '0;
      c_r[0]   <= in_ctx;
    end
  end

  for (genvar i = 1; i <= DIV_STAGES; i++) begin : g_step
    logic [32:0] r2;
    logic        ge;
    always_comb begin
      r2 = {rem_r[i-1], low_r[i-1][31]};
      ge = r2 >= {1'b0, gain_a};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? 32'(r2 - {1'b0, gain_a}) : r2[31:0];
        low_r[i] <= {low_r[i-1][30:0], 1'b0};
        q_r[i]   <= {q_r[i-1][30:0], ge};
        neg_r[i] <= neg_r[i-1];
        ovf_r[i] <= ovf_r[i-1];
        az_r[i]  <= az_r[i-1];
        nz_r[i]  <= nz_r[i-1];
        c_r[i]   <= c_r[i-1];
      end
    end
  end

  logic signed [31:0] f_nxt;
  logic               fs_nxt;
  logic [31:0]        ql;

  always_comb begin
    ql     = q_r[DIV_STAGES];
    fs_nxt = 1'b0;
    if (az_r[DIV_STAGES]) begin
      fs_nxt = nz_r[DIV_STAGES];
      f_nxt  = !nz_r[DIV_STAGES] ? '0 : (neg_r[DIV_STAGES] ? S32_MIN : S32_MAX);
    end else if (neg_r[DIV_STAGES]) begin
      f_nxt = (ovf_r[DIV_STAGES] || ql[31]) ? S32_MIN : -$signed(ql);
    end else if (ovf_r[DIV_STAGES] || ql[31]) begin
      fs_nxt = 1'b1;
      f_nxt  = S32_MAX;
    end else begin
      f_nxt = $signed(ql);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_r  <= f_nxt;
      fc_r <= '{ep: c_r[DIV_STAGES].ep, ev: c_r[DIV_STAGES].ev,
                sat: c_r[DIV_STAGES].sat | fs_nxt};
    end
  end

  assign out_valid = fv_r;
  assign f         = f_r;
  assign out_ctx   = fc_r;

endmodule

// File: src/amig_back.sv
`timescale 1ns / 1ps
// Back pipeline: K, D, torque terms, clamps and the output register.
// Depends on amig_pkg.
module amig_back import amig_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] f,
  input  ctx_t               in_ctx,
  output logic               out_valid,
  output logic        [24:0] stiffness,
  output logic        [18:0] damping,
  output logic signed [20:0] feedforward_force,
  output logic signed [31:0] torque,
  output logic               torque_saturated
);

  logic [3:0] v_r;
  logic signed [63:0] kp_r, dp_r, t1p_r, t2p_r;
  logic signed [31:0] f1_r, f2_r, f3_r, k2_r, d2_r, k3_r, d3_r;
  ctx_t c1_r, c2_r, c3_r;
  logic [24:0] stiff_r;
  logic [18:0] damp_r;
  logic signed [20:0] ff_r;
  logic signed [31:0] tau_r;
  logic sat_r;

  satv_t s_k, s_d, s_t1, s_t2, s_tau;
  logic signed [31:0] kc, dc, fc;

  always_comb begin
    s_k   = qsat(kp_r);
    s_d   = qsat(dp_r);
    s_t1  = qsat(t1p_r);
    s_t2  = qsat(t2p_r);
    s_tau = sat32(-66'(s_t1.val) - 66'(s_t2.val) - 66'(f3_r));
    kc = (k3_r >= K_MAX) ? K_MAX : ((k3_r <= 0) ? 32'sd0 : k3_r);
    dc = (d3_r >= D_MAX) ? D_MAX : ((d3_r <= 0) ? 32'sd0 : d3_r);
    fc = (f3_r >= FF_LIM) ? FF_LIM : ((f3_r <= -FF_LIM) ? -FF_LIM : f3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kp_r    <= f * in_ctx.ep;
      dp_r    <= f * in_ctx.ev;
      f1_r    <= f;
      c1_r    <= in_ctx;
      k2_r    <= s_k.val;
      d2_r    <= s_d.val;
      f2_r    <= f1_r;
      c2_r    <= '{ep: c1_r.ep, ev: c1_r.ev, sat: c1_r.sat | s_k.sat | s_d.sat};
      t1p_r   <= k2_r * c2_r.ep;
      t2p_r   <= d2_r * c2_r.ev;
      k3_r    <= k2_r;
      d3_r    <= d2_r;
      f3_r    <= f2_r;
      c3_r    <= c2_r;
      stiff_r <= kc[24:0];
      damp_r  <= dc[18:0];
      ff_r    <= 21'(-fc);
      tau_r   <= s_tau.val;
      sat_r   <= c3_r.sat | s_t1.sat | s_t2.sat | s_tau.sat;
    end
  end

  assign out_valid         = v_r[3];
  assign stiffness         = stiff_r;
  assign damping           = damp_r;
  assign feedforward_force = ff_r;
  assign torque            = tau_r;
  assign torque_saturated  = sat_r;

endmodule

// File: src/adaptive_muscle_impedance_gain_core.sv
`timescale 1ns / 1ps
// Adaptive muscle impedance gain core: top level, config registers, stall control.
// Depends on amig_pkg, amig_in_if, amig_out_if, amig_front, amig_div, amig_back.
//
// Usage:
//   in_ch carries one item per joint sample (desired and measured position and
//   velocity, signed Q16.16). out_ch returns one result per item: stiffness,
//   damping, feed-forward force, torque and a saturation flag.
//   From acceptance to out_ch.valid an item passes eight front stages,
//   a prep stage, 32 divider stages (one quotient bit each), a result stage
//   and four back stages ending in the output register.
//   Throughput is one item per cycle while out_ch does not stall; the divider is fully pipelined.
//   Gains a, b and beta (cfg index 0, 1, 2; others ignored) are written by the
//   user only while the pipeline is empty; the core does not enforce this.
//   Reset (rst_n low, synchronous) empties the pipeline and restores a = 1.0,
//   b = 0, beta = 0.
//   When out_ch.ready is low with a result waiting, the whole pipeline holds
//   and in_ch.ready drops in the same cycle; nothing is lost or repeated.
module adaptive_muscle_impedance_gain_core import amig_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  amig_in_if.sink     in_ch,
  amig_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] gain_a_r, gain_b_r, beta_r;
  logic        en;

  logic               fv, dv;
  logic signed [63:0] num;
  ctx_t               fctx, dctx;
  logic signed [31:0] f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_a_r <= QONE;
      gain_b_r <= '0;
      beta_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GAIN_A: gain_a_r <= cfg_data;
        REG_GAIN_B: gain_b_r <= cfg_data;
        REG_BETA:   beta_r   <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  amig_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .pd        (in_ch.desired_position),
    .vd        (in_ch.desired_velocity),
    .pf        (in_ch.measured_position),
    .vf        (in_ch.measured_velocity),
    .gain_b    (gain_b_r),
    .beta      (beta_r),
    .out_valid (fv),
    .num       (num),
    .ctx       (fctx)
  );

  amig_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fv),
    .num       (num),
    .in_ctx    (fctx),
    .gain_a    (gain_a_r),
    .out_valid (dv),
    .f         (f),
    .out_ctx   (dctx)
  );

  amig_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .en                (en),
    .in_valid          (dv),
    .f                 (f),
    .in_ctx            (dctx),
    .out_valid         (out_ch.valid),
    .stiffness         (out_ch.stiffness),
    .damping           (out_ch.damping),
    .feedforward_force (out_ch.feedforward_force),
    .torque            (out_ch.torque),
    .torque_saturated  (out_ch.torque_saturated)
  );

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for adaptive_muscle_impedance_gain_core: a directed table,
// then random items over several gain settings, checked against a Q16.16 predictor.
// Depends on amig_pkg, amig_in_if, amig_out_if and the core RTL.
module tb;
  import amig_pkg::*;

  localparam int LATENCY  = 46;
  localparam int WD_LIMIT = 4000;
  localparam int HOLD_LEN = 300;
  localparam int N_RAND   = 1080;

  typedef struct packed {
    logic signed [31:0] pd;
    logic signed [31:0] vd;
    logic signed [31:0] pm;
    logic signed [31:0] vm;
  } sample_t;

  typedef struct packed {
    logic        [24:0] stiff;
    logic        [18:0] damp;
    logic signed [20:0] ff;
    logic signed [31:0] torque;
    logic               sat;
  } gains_t;

  typedef struct {
    sample_t s;
    bit      fixed;
    gains_t  g;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_NONE;
  logic [31:0] cfg_data = '0;

  amig_in_if in_ch();
  amig_out_if out_ch();

  adaptive_muscle_impedance_gain_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  logic [31:0] gain_a = QONE;
  logic [31:0] gain_b = '0;
  logic [31:0] beta = '0;
  gains_t pending_results[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int hold_cnt = 0;
  bit cur_fixed = 0;
  gains_t cur_gains;
  bit model_sat;
  int quiet = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.desired_position = '0;
    in_ch.desired_velocity = '0;
    in_ch.measured_position = '0;
    in_ch.measured_velocity = '0;
    out_ch.ready = 1'b0;
  end

  function automatic longint clip32(input logic signed [127:0] x);
    if (x > 128'sd2147483647) begin
      model_sat = 1;
      return 64'sd2147483647;
    end
    if (x < -128'sd2147483648) begin
      model_sat = 1;
      return -64'sd2147483648;
    end
    return longint'(x);
  endfunction

  function automatic longint qprod(input longint x, input longint y);
    logic signed [127:0] p;
    p = $signed(x) * $signed(y);
    return clip32(p >>> 16);
  endfunction

  function automatic longint clampv(input longint v, input longint lo, input longint hi);
    if (v >= hi) return hi;
    if (v <= lo) return lo;
    return v;
  endfunction

  function automatic gains_t impedance_gains(input sample_t s);
    longint ep, ev, e, e2, be2, den, num, f, k, d, tau;
    longint unsigned mag, q;
    gains_t g;
    model_sat = 0;
    ep = clip32(longint'(s.pm) - longint'(s.pd));
    ev = clip32(longint'(s.vm) - longint'(s.vd));
    e = clip32(ep + qprod(longint'({32'b0, beta}), ev));
    e2 = qprod(e, e);
    be2 = qprod(longint'({32'b0, gain_b}), e2);
    den = clip32(longint'(QONE) + be2);
    num = e * den;
    mag = (num < 0) ? longint'(-num) : num;
    if (gain_a == 0) begin
      if (mag == 0) f = 0;
      else begin
        model_sat = 1;
        f = (num < 0) ? -64'sd2147483648 : 64'sd2147483647;
      end
    end else begin
      q = mag / {32'b0, gain_a};
      if (q > 64'd2147483648) q = 64'd2147483648;
      f = clip32((num < 0) ? -longint'(q) : longint'(q));
    end
    k = qprod(f, ep);
    d = qprod(f, ev);
    tau = clip32(-qprod(k, ep) - qprod(d, ev) - f);
    g.stiff = 25'(clampv(k, 0, K_MAX));
    g.damp = 19'(clampv(d, 0, D_MAX));
    g.ff = 21'(-clampv(f, -FF_LIM, FF_LIM));
    g.torque = 32'(tau);
    g.sat = model_sat;
    return g;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // receiver: random stalls, or one long hold when asked
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HOLD_LEN) hold_done <= 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      pending_results.push_back(cur_fixed ? cur_gains :
        impedance_gains({in_ch.desired_position, in_ch.desired_velocity,
                         in_ch.measured_position, in_ch.measured_velocity}));
    end
    if (out_ch.valid && out_ch.ready) begin
      gains_t w;
      if (pending_results.size() == 0) begin
        $display("unexpected item at %0t", $realtime);
        errors++;
      end else begin
        w = pending_results.pop_front();
        if (out_ch.stiffness !== w.stiff) report_mismatch("stiffness", out_ch.stiffness, w.stiff);
        if (out_ch.damping !== w.damp) report_mismatch("damping", out_ch.damping, w.damp);
        if (out_ch.feedforward_force !== w.ff)
          report_mismatch("feedforward_force", out_ch.feedforward_force, w.ff);
        if (out_ch.torque !== w.torque) report_mismatch("torque", out_ch.torque, w.torque);
        if (out_ch.torque_saturated !== w.sat)
          report_mismatch("torque_saturated", out_ch.torque_saturated, w.sat);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else if (rst_n) quiet <= quiet + 1;
    if (quiet >= WD_LIMIT) begin
      $display("FAIL adaptive_muscle_impedance_gain_core");
      $finish;
    end
  end

  task automatic send_sample(input sample_t s, input bit fixed, input gains_t g);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.desired_position <= s.pd;
    in_ch.desired_velocity <= s.vd;
    in_ch.measured_position <= s.pm;
    in_ch.measured_velocity <= s.vm;
    cur_fixed <= fixed;
    cur_gains <= g;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_gains(input logic [31:0] a, input logic [31:0] b, input logic [31:0] bw);
    in_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_GAIN_A; cfg_data <= a; @(negedge clk);
    cfg_index <= REG_GAIN_B; cfg_data <= b; @(negedge clk);
    cfg_index <= REG_BETA; cfg_data <= bw; @(negedge clk);
    cfg_index <= REG_NONE; cfg_data <= $urandom; @(negedge clk);
    cfg_we <= 1'b0;
    gain_a = a;
    gain_b = b;
    beta = bw;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] near(input logic signed [31:0] base, input int span);
    return base + $signed(32'($urandom_range(0, 2 * span)) - 32'(span));
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    case ($urandom_range(3))
      0: s = {$urandom, $urandom, $urandom, $urandom};
      1: begin
        s.pd = $urandom; s.vd = $urandom;
        s.pm = near(s.pd, 1 << 18); s.vm = near(s.vd, 1 << 18);
      end
      2: begin
        s.pd = near(0, 1 << 21); s.vd = near(0, 1 << 20);
        s.pm = near(s.pd, 1 << 17); s.vm = near(s.vd, 1 << 16);
      end
      default: begin
        s.pd = near(0, 1 << 16); s.vd = near(0, 1 << 16);
        s.pm = near(0, 1 << 16); s.vm = near(0, 1 << 16);
      end
    endcase
    return s;
  endfunction

  row_t directed[] = '{
    '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1, '{25'd0, 19'd0, 21'sd0, 32'sd0, 1'b0}},
    '{'{32'sd0, 32'sd0, 32'sd65536, 32'sd0}, 1,
      '{25'd65536, 19'd0, -21'sd65536, -32'sd131072, 1'b0}},
    '{'{S32_MIN, 32'sd0, S32_MAX, 32'sd0}, 1,
      '{25'd32768000, 19'd0, -21'sd983040, S32_MIN, 1'b1}},
    '{'{S32_MAX, S32_MIN, S32_MIN, S32_MAX}, 0, '0},
    '{'{32'sd0, 32'sd0, -32'sd65536, 32'sd65536}, 0, '0},
    '{'{32'sd65536, 32'sd0, 32'sd0, 32'sd131072}, 0, '0},
    '{'{32'sd0, 32'sd0, 32'sd983040, 32'sd0}, 0, '0},
    '{'{32'sd0, 32'sd0, -32'sd983040, 32'sd0}, 0, '0},
    '{'{32'sd0, 32'sd0, 32'sd1000000, -32'sd300000}, 0, '0},
    '{'{32'shffffffff, 32'sh55555555, 32'shaaaaaaaa, 32'sd1}, 0, '0}
  };

  initial begin
    logic [31:0] gain_set[6][3];
    gain_set = '{
      '{QONE, 32'd0, 32'd0},
      '{32'd1, 32'd0, 32'd0},
      '{32'hffffffff, 32'hffffffff, 32'hffffffff},
      '{32'd131072, 32'd32768, 32'd16384},
      '{32'd0, 32'd65536, 32'd65536},
      '{$urandom, $urandom_range(0, 1 << 18), $urandom_range(0, 1 << 17)}
    };
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) send_sample(directed[i].s, directed[i].fixed, directed[i].g);
    write_gains(32'd1, 32'd0, 32'hffffffff);
    foreach (directed[i]) send_sample(directed[i].s, 0, '0);
    for (int p = 0; p < 6; p++) begin
      write_gains(gain_set[p][0], gain_set[p][1], gain_set[p][2]);
      for (int n = 0; n < N_RAND / 6; n++) begin
        int idx;
        idx = p * (N_RAND / 6) + n;
        if (idx < N_RAND / 3) begin
          send_idle = 26; recv_idle = 53;
        end else if (idx < 2 * N_RAND / 3) begin
          send_idle = 53; recv_idle = 26;
        end else begin
          send_idle = 0; recv_idle = 0;
        end
        if (p == 1 && n == 10) begin
          send_idle = 0;
          hold_req = 1;
        end
        send_sample(random_sample(), 0, '0);
      end
    end
    in_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS adaptive_muscle_impedance_gain_core");
    end else begin
      $display("FAIL adaptive_muscle_impedance_gain_core");
    end
    $finish;
  end
endmodule

// File: adaptive_muscle_impedance_gain_core.f
src/amig_pkg.sv
src/amig_in_if.sv
src/amig_out_if.sv
src/amig_front.sv
src/amig_div.sv
src/amig_back.sv
src/adaptive_muscle_impedance_gain_core.sv
bench/tb.sv
